// ===== rtl/grd_pkg.sv =====
// Types, constants and per-stage stick arithmetic for the gamepad radial deadzone.
`timescale 1ns / 1ps
package grd_pkg;

  localparam int unsigned BUTTON_COUNT = 15;
  localparam logic [14:0] BUTTON_MASK = 15'((33'd1 << BUTTON_COUNT) - 33'd1);
  localparam logic [14:0] DZ_RESET = 15'd4915;
  localparam logic [16:0] ONE_Q15 = 17'd32768;
  localparam logic [14:0] SAT_MAX = 15'd32767;

  // Stage map: entry, squares, sum, 16 root steps, products, overflow check,
  // 15 divide steps, output assembly.
  localparam int ST_SQ = 1;
  localparam int ST_SUM = 2;
  localparam int ROOT_STEPS = 16;
  localparam int ST_RT0 = 3;
  localparam int ST_MUL = ST_RT0 + ROOT_STEPS;
  localparam int ST_CMP = ST_MUL + 1;
  localparam int DIV_STEPS = 15;
  localparam int ST_DV0 = ST_CMP + 1;
  localparam int ST_OUT = ST_DV0 + DIV_STEPS;
  localparam int N_STAGES = ST_OUT + 1;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic [30:0]        xx;
    logic [30:0]        yy;
    logic [29:0]        dzsq;
    logic [31:0]        sq;
    logic               in_dz;
    logic [17:0]        rem;
    logic [15:0]        root;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [31:0]        den;
    logic               satx;
    logic               saty;
    logic [31:0]        rx;
    logic [31:0]        ry;
    logic [14:0]        qx;
    logic [14:0]        qy;
    logic signed [15:0] xo;
    logic signed [15:0] yo;
  } stick_t;

  typedef struct packed {
    logic        present;
    logic [14:0] buttons;
    logic [14:0] ltrig;
    logic [14:0] rtrig;
    logic [14:0] dz;
    stick_t      ls;
    stick_t      rs;
  } item_t;

  // Squares of both components and of the radius
  function automatic stick_t stk_prod(stick_t s, logic [14:0] dz);
    stick_t o;
    logic signed [33:0] px;
    logic signed [33:0] py;
    logic [29:0] d;
    o = s;
    px = s.x * s.x;
    py = s.y * s.y;
    d = 30'(dz);
    o.xx = px[30:0];
    o.yy = py[30:0];
    o.dzsq = d * d;
    return o;
  endfunction

  // Squared length and inside test; clear the root state
  function automatic stick_t stk_sum(stick_t s);
    stick_t o;
    o = s;
    o.sq = 32'(s.xx) + 32'(s.yy);
    o.in_dz = o.sq < 32'(s.dzsq);
    o.rem = '0;
    o.root = '0;
    return o;
  endfunction

  // One bit of the integer square root, bit pair i of sq
  function automatic stick_t stk_root(stick_t s, int i);
    stick_t o;
    logic [19:0] r;
    logic [19:0] trial;
    o = s;
    r = {s.rem, s.sq[2*i +: 2]};
    trial = {2'b00, s.root, 2'b01};
    if (r >= trial) begin
      r = r - trial;
      o.root = {s.root[14:0], 1'b1};
    end else begin
      o.root = {s.root[14:0], 1'b0};
    end
    o.rem = r[17:0];
    return o;
  endfunction

  // Numerators mag*(len-dz) and denominator (1-dz)*len
  function automatic stick_t stk_mul(stick_t s, logic [14:0] dz);
    stick_t o;
    logic [16:0] mx;
    logic [16:0] my;
    logic [15:0] lmd;
    logic [16:0] omd;
    o = s;
    mx = s.x[16] ? 17'(-s.x) : 17'(s.x);
    my = s.y[16] ? 17'(-s.y) : 17'(s.y);
    lmd = s.root - {1'b0, dz};
    omd = ONE_Q15 - {2'b00, dz};
    // Full 17-bit magnitude and 1-dz: both reach 2^15
    o.ax = 32'(mx) * 32'(lmd);
    o.ay = 32'(my) * 32'(lmd);
    o.den = 32'(omd) * 32'(s.root);
    return o;
  endfunction

  // Quotient of 2^15 or more saturates
  function automatic stick_t stk_cmp(stick_t s);
    stick_t o;
    o = s;
    o.satx = s.ax >= s.den;
    o.saty = s.ay >= s.den;
    o.rx = s.ax;
    o.ry = s.ay;
    o.qx = '0;
    o.qy = '0;
    return o;
  endfunction

  // One restoring divide step for both components
  function automatic stick_t stk_div(stick_t s);
    stick_t o;
    logic [31:0] tx;
    logic [31:0] ty;
    o = s;
    tx = {s.rx[30:0], 1'b0};
    ty = {s.ry[30:0], 1'b0};
    if (tx >= s.den) begin
      o.rx = tx - s.den;
      o.qx = {s.qx[13:0], 1'b1};
    end else begin
      o.rx = tx;
      o.qx = {s.qx[13:0], 1'b0};
    end
    if (ty >= s.den) begin
      o.ry = ty - s.den;
      o.qy = {s.qy[13:0], 1'b1};
    end else begin
      o.ry = ty;
      o.qy = {s.qy[13:0], 1'b0};
    end
    return o;
  endfunction

  // Zero inside the radius or at zero length, saturate, restore the sign
  function automatic stick_t stk_out(stick_t s);
    stick_t o;
    logic zero;
    logic [15:0] mx;
    logic [15:0] my;
    o = s;
    zero = s.in_dz || (s.root == '0);
    mx = zero ? 16'd0 : (s.satx ? {1'b0, SAT_MAX} : {1'b0, s.qx});
    my = zero ? 16'd0 : (s.saty ? {1'b0, SAT_MAX} : {1'b0, s.qy});
    o.xo = s.x[16] ? -$signed(mx) : $signed(mx);
    o.yo = s.y[16] ? -$signed(my) : $signed(my);
    return o;
  endfunction

endpackage

// ===== rtl/gamepad_radial_deadzone.sv =====
// Gamepad frame conditioner: radial stick deadzone with rescale, trigger remap.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | pad frame fields
//  out     | output    | out_valid_o/out_ready_i | conditioned frame fields
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (deadzone radius)
//
// One frame per cycle unless the output stalls. Stages: entry, squares, sum,
// 16 square-root steps, products, overflow check, 15 divide steps, output.
// Reset clears all stage valid bits and loads the radius with 0.15 (4915).
// A stalled output holds; empty stages ahead of a stall still fill, so input
// is taken while any stage is free. The radius register is always writable.
`timescale 1ns / 1ps
module gamepad_radial_deadzone (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               pad_present_i,
  input  logic [14:0]        button_mask_i,
  input  logic signed [15:0] left_x_i,
  input  logic signed [15:0] left_y_i,
  input  logic signed [15:0] right_x_i,
  input  logic signed [15:0] right_y_i,
  input  logic signed [15:0] left_trig_i,
  input  logic signed [15:0] right_trig_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               connected_o,
  output logic [14:0]        buttons_out_o,
  output logic signed [15:0] left_x_out_o,
  output logic signed [15:0] left_y_out_o,
  output logic signed [15:0] right_x_out_o,
  output logic signed [15:0] right_y_out_o,
  output logic [14:0]        left_trig_out_o,
  output logic [14:0]        right_trig_out_o
);

  localparam int Last = grd_pkg::N_STAGES - 1;

  logic [14:0]                  dz_q;
  grd_pkg::item_t               pipe_q [grd_pkg::N_STAGES];
  grd_pkg::item_t               pipe_d [grd_pkg::N_STAGES];
  logic [grd_pkg::N_STAGES-1:0] vld_q;
  logic [grd_pkg::N_STAGES-1:0] rdy;

  // Radius register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= grd_pkg::DZ_RESET;
    end else if (cfg_valid_i) begin
      dz_q <= cfg_data_i;
    end
  end

  // Stage k loads when it is empty or its item moves on
  always_comb begin
    rdy[Last] = !vld_q[Last] || out_ready_i;
    for (int k = Last - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];

  // Next value of every stage
  always_comb begin
    pipe_d[0] = '0;
    pipe_d[0].present = pad_present_i;
    pipe_d[0].buttons = button_mask_i & grd_pkg::BUTTON_MASK;
    pipe_d[0].ltrig = {~left_trig_i[15], left_trig_i[14:1]};
    pipe_d[0].rtrig = {~right_trig_i[15], right_trig_i[14:1]};
    pipe_d[0].dz = dz_q;
    pipe_d[0].ls.x = 17'(left_x_i);
    pipe_d[0].ls.y = -17'(left_y_i);
    pipe_d[0].rs.x = 17'(right_x_i);
    pipe_d[0].rs.y = -17'(right_y_i);
    for (int k = 1; k < grd_pkg::N_STAGES; k++) begin
      pipe_d[k] = pipe_q[k-1];
      if (k == grd_pkg::ST_SQ) begin
        pipe_d[k].ls = grd_pkg::stk_prod(pipe_q[k-1].ls, pipe_q[k-1].dz);
        pipe_d[k].rs = grd_pkg::stk_prod(pipe_q[k-1].rs, pipe_q[k-1].dz);
      end else if (k == grd_pkg::ST_SUM) begin
        pipe_d[k].ls = grd_pkg::stk_sum(pipe_q[k-1].ls);
        pipe_d[k].rs = grd_pkg::stk_sum(pipe_q[k-1].rs);
      end else if (k < grd_pkg::ST_MUL) begin
        pipe_d[k].ls = grd_pkg::stk_root(pipe_q[k-1].ls,
                                         grd_pkg::ROOT_STEPS - 1 - (k - grd_pkg::ST_RT0));
        pipe_d[k].rs = grd_pkg::stk_root(pipe_q[k-1].rs,
                                         grd_pkg::ROOT_STEPS - 1 - (k - grd_pkg::ST_RT0));
      end else if (k == grd_pkg::ST_MUL) begin
        pipe_d[k].ls = grd_pkg::stk_mul(pipe_q[k-1].ls, pipe_q[k-1].dz);
        pipe_d[k].rs = grd_pkg::stk_mul(pipe_q[k-1].rs, pipe_q[k-1].dz);
      end else if (k == grd_pkg::ST_CMP) begin
        pipe_d[k].ls = grd_pkg::stk_cmp(pipe_q[k-1].ls);
        pipe_d[k].rs = grd_pkg::stk_cmp(pipe_q[k-1].rs);
      end else if (k < grd_pkg::ST_OUT) begin
        pipe_d[k].ls = grd_pkg::stk_div(pipe_q[k-1].ls);
        pipe_d[k].rs = grd_pkg::stk_div(pipe_q[k-1].rs);
      end else begin
        pipe_d[k].ls = grd_pkg::stk_out(pipe_q[k-1].ls);
        pipe_d[k].rs = grd_pkg::stk_out(pipe_q[k-1].rs);
      end
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < grd_pkg::N_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < grd_pkg::N_STAGES; k++) begin
      if (rdy[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // Output; an absent pad zeroes the frame
  assign out_valid_o      = vld_q[Last];
  assign connected_o      = pipe_q[Last].present;
  assign buttons_out_o    = pipe_q[Last].present ? pipe_q[Last].buttons : '0;
  assign left_x_out_o     = pipe_q[Last].present ? pipe_q[Last].ls.xo : '0;
  assign left_y_out_o     = pipe_q[Last].present ? pipe_q[Last].ls.yo : '0;
  assign right_x_out_o    = pipe_q[Last].present ? pipe_q[Last].rs.xo : '0;
  assign right_y_out_o    = pipe_q[Last].present ? pipe_q[Last].rs.yo : '0;
  assign left_trig_out_o  = pipe_q[Last].present ? pipe_q[Last].ltrig : '0;
  assign right_trig_out_o = pipe_q[Last].present ? pipe_q[Last].rtrig : '0;

endmodule

// ===== rtl/grd_checker.sv =====
// Port-level checks on the gamepad radial deadzone, bound to the top level.
`timescale 1ns / 1ps
module grd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               connected_o,
  input logic [14:0]        buttons_out_o,
  input logic signed [15:0] left_x_out_o,
  input logic signed [15:0] left_y_out_o,
  input logic signed [15:0] right_x_out_o,
  input logic signed [15:0] right_y_out_o,
  input logic [14:0]        left_trig_out_o,
  input logic [14:0]        right_trig_out_o
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_x_out_o)
      && $stable(right_y_out_o) && $stable(connected_o))
    else $error("stalled result changed");

  // Absent pad gives an all-zero frame
  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !connected_o |-> buttons_out_o == '0 && left_x_out_o == '0
      && left_y_out_o == '0 && right_x_out_o == '0 && right_y_out_o == '0
      && left_trig_out_o == '0 && right_trig_out_o == '0)
    else $error("absent pad frame not zero");

  // Saturation is symmetric: the most negative code never appears
  a_left_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_x_out_o != 16'sh8000 && left_y_out_o != 16'sh8000)
    else $error("left stick beyond -32767");

  a_right_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> right_x_out_o != 16'sh8000 && right_y_out_o != 16'sh8000)
    else $error("right stick beyond -32767");

endmodule

bind gamepad_radial_deadzone grd_checker u_grd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .connected_o      (connected_o),
  .buttons_out_o    (buttons_out_o),
  .left_x_out_o     (left_x_out_o),
  .left_y_out_o     (left_y_out_o),
  .right_x_out_o    (right_x_out_o),
  .right_y_out_o    (right_y_out_o),
  .left_trig_out_o  (left_trig_out_o),
  .right_trig_out_o (right_trig_out_o)
);
